// ----- hw/rtl/okvt_pkg.sv -----
// Shared types, sizes and opcodes for the ordered key/value table.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package okvt_pkg;

  localparam int DEPTH      = 256;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  // Stored widths: the request fields are 32 bits wide.
  localparam int KEY_W = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int VAL_W = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

  // Match gathering: groups reduced in the accept cycle, groups combined next.
  localparam int GRP  = 16;
  localparam int NGRP = (DEPTH + GRP - 1) / GRP;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [VAL_W-1:0] val_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_UPDATE = 3'd1;
  localparam logic [2:0] OP_UPSERT = 3'd2;
  localparam logic [2:0] OP_ERASE  = 3'd3;
  localparam logic [2:0] OP_LOOKUP = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] key;
    logic [31:0] new_value;
    logic [7:0]  position;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] found_key;
    logic [31:0] found_value;
    logic [8:0]  entry_count;
    logic        is_empty;
  } res_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_INSERT,
    CMD_UPDATE,
    CMD_ERASE
  } cmd_kind_t;

  // Broadcast to every cell while a request is looked up.
  typedef struct packed {
    logic       cap;
    key_t       key;
    logic [7:0] pos;
    cnt_t       count;
  } look_t;

  // Broadcast to every cell when a request commits.
  typedef struct packed {
    cmd_kind_t kind;
    key_t      key;
    val_t      val;
    idx_t      erase_idx;
    cnt_t      count;
  } cmd_t;

  typedef struct packed {
    logic hit;
    idx_t hit_idx;
    val_t hit_val;
    logic pos_ok;
    key_t pos_key;
    val_t pos_val;
  } gather_t;

  typedef enum logic {
    S_IDLE,
    S_RESOLVE
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ordered_key_value_table_top.sv -----
// Ordered key/value table (okvt_pkg, okvt_cell, okvt_gather): DEPTH slots packed in order.
// Result: registered when the request commits in the resolve state, which waits while stalled.
// Throughput: one request at a time (accept, then resolve), set by the cell-compare /
// group-gather step followed by the final gather and commit.
// Reset (rst_n low, synchronous) empties the table and drops any result;
// slot contents are not cleared and are only read below the entry count.
`default_nettype none

module ordered_key_value_table_top import okvt_pkg::*; (
  input  wire   clk,
  input  wire   rst_n,
  input  wire   in_valid,
  output logic  in_ready,
  input  req_t  in_data,
  output logic  out_valid,
  input  wire   out_ready,
  output res_t  out_data
);

  state_t  state_r, state_nxt;
  cnt_t    count_r, count_nxt;
  req_t    req_r;
  logic    out_valid_r, out_valid_nxt;
  res_t    out_data_r, out_data_nxt;

  logic    in_accept;
  logic    commit;
  look_t   look;
  cmd_t    cmd;
  gather_t gat;

  logic [DEPTH-1:0] match;
  logic [DEPTH-1:0] pos_hit;
  key_t             keys   [DEPTH];
  val_t             vals   [DEPTH];
  key_t             nb_key [DEPTH];
  val_t             nb_val [DEPTH];

  assign in_accept = in_valid && in_ready;

  // Lookup broadcast: every cell compares against the incoming request.
  assign look.cap   = in_accept;
  assign look.key   = in_data.key[KEY_W-1:0];
  assign look.pos   = in_data.position;
  assign look.count = count_r;

  // Cell chain; on erase each slot at or above the erased one pulls from its upper neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i < DEPTH - 1) begin : g_nb
      assign nb_key[i] = keys[i + 1];
      assign nb_val[i] = vals[i + 1];
    end else begin : g_last
      assign nb_key[i] = keys[i];
      assign nb_val[i] = vals[i];
    end

    okvt_cell u_cell (
      .clk     (clk),
      .idx     (idx_t'(i)),
      .look    (look),
      .cmd     (cmd),
      .nb_key  (nb_key[i]),
      .nb_val  (nb_val[i]),
      .match_c (match[i]),
      .pos_c   (pos_hit[i]),
      .key_o   (keys[i]),
      .val_o   (vals[i])
    );
  end

  okvt_gather u_gather (
    .clk     (clk),
    .cap     (in_accept),
    .match   (match),
    .pos_hit (pos_hit),
    .keys    (keys),
    .vals    (vals),
    .res     (gat)
  );

  // FSM next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  // FSM outputs: resolve waits until the output register is free
  always_comb begin
    in_ready = 1'b0;
    commit   = 1'b0;
    unique case (state_r)
      S_IDLE:    in_ready = 1'b1;
      S_RESOLVE: commit   = !out_valid_r || out_ready;
    endcase
  end

  // Operation decode in the resolve cycle
  logic full;
  logic ok;
  logic [31:0] fk, fv;
  logic [31:0] req_key_ext;

  assign full        = (count_r == cnt_t'(DEPTH));
  assign req_key_ext = 32'(req_r.key[KEY_W-1:0]);

  always_comb begin
    ok            = 1'b0;
    fk            = req_key_ext;
    fv            = '0;
    count_nxt     = count_r;
    cmd.kind      = CMD_NONE;
    cmd.key       = req_r.key[KEY_W-1:0];
    cmd.val       = req_r.new_value[VAL_W-1:0];
    cmd.erase_idx = gat.hit_idx;
    cmd.count     = count_r;
    unique case (req_r.opcode)
      OP_INSERT: begin
        ok = !full && !gat.hit;
        if (ok) begin
          cmd.kind  = CMD_INSERT;
          count_nxt = cnt_t'(count_r + 1'b1);
        end
      end
      OP_UPDATE: begin
        ok = gat.hit;
        if (ok) begin
          cmd.kind = CMD_UPDATE;
        end
      end
      OP_UPSERT: begin
        if (gat.hit) begin
          ok       = 1'b1;
          cmd.kind = CMD_UPDATE;
        end else if (!full) begin
          ok        = 1'b1;
          cmd.kind  = CMD_INSERT;
          count_nxt = cnt_t'(count_r + 1'b1);
        end
      end
      OP_ERASE: begin
        ok = gat.hit;
        if (ok) begin
          cmd.kind  = CMD_ERASE;
          count_nxt = cnt_t'(count_r - 1'b1);
        end
      end
      OP_LOOKUP: begin
        ok = gat.hit;
        fv = gat.hit ? 32'(gat.hit_val) : '0;
      end
      OP_READ: begin
        ok = gat.pos_ok;
        fk = gat.pos_ok ? 32'(gat.pos_key) : '0;
        fv = gat.pos_ok ? 32'(gat.pos_val) : '0;
      end
      default: begin
      end
    endcase
    // nothing touches the table unless the result can be taken
    if (!commit) begin
      cmd.kind  = CMD_NONE;
      count_nxt = count_r;
    end
  end

  // Output register
  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (commit) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.ok          = ok;
      out_data_nxt.found_key   = fk;
      out_data_nxt.found_value = fv;
      out_data_nxt.entry_count = 9'(count_nxt);
      out_data_nxt.is_empty    = (count_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- hw/rtl/okvt_cell.sv -----
// One slot of the table: key/value storage, local key and position compare,
// and the per-slot update/insert/shift-down decision. Uses okvt_pkg.
`default_nettype none

module okvt_cell import okvt_pkg::*; (
  input  wire        clk,
  input  idx_t       idx,
  input  look_t      look,
  input  cmd_t       cmd,
  input  key_t       nb_key,
  input  val_t       nb_val,
  output logic       match_c,
  output logic       pos_c,
  output key_t       key_o,
  output val_t       val_o
);

  key_t key_r, key_nxt;
  val_t val_r, val_nxt;
  logic match_r;
  logic in_range;

  assign in_range = CMP_W'(idx) < CMP_W'(look.count);
  assign match_c  = in_range && (key_r == look.key);
  assign pos_c    = in_range && (CMP_W'(idx) == CMP_W'(look.pos));
  assign key_o    = key_r;
  assign val_o    = val_r;

  always_comb begin
    key_nxt = key_r;
    val_nxt = val_r;
    unique case (cmd.kind)
      CMD_UPDATE: begin
        if (match_r) begin
          val_nxt = cmd.val;
        end
      end
      CMD_INSERT: begin
        if (CMP_W'(idx) == CMP_W'(cmd.count)) begin
          key_nxt = cmd.key;
          val_nxt = cmd.val;
        end
      end
      CMD_ERASE: begin
        // slots at and above the erased one take their upper neighbor
        if (idx >= cmd.erase_idx) begin
          key_nxt = nb_key;
          val_nxt = nb_val;
        end
      end
      CMD_NONE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (look.cap) begin
      match_r <= match_c;
    end
    key_r <= key_nxt;
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/okvt_gather.sv -----
// Two-level OR reduction of the one-hot key and position hits of all cells:
// groups are reduced and registered at accept, then combined. Uses okvt_pkg.
`default_nettype none

module okvt_gather import okvt_pkg::*; (
  input  wire              clk,
  input  wire              cap,
  input  wire [DEPTH-1:0]  match,
  input  wire [DEPTH-1:0]  pos_hit,
  input  key_t             keys [DEPTH],
  input  val_t             vals [DEPTH],
  output gather_t          res
);

  logic hit_c    [NGRP];
  idx_t idx_c    [NGRP];
  val_t val_c    [NGRP];
  logic pok_c    [NGRP];
  key_t pkey_c   [NGRP];
  val_t pval_c   [NGRP];

  logic hit_r    [NGRP];
  idx_t idx_r    [NGRP];
  val_t val_r    [NGRP];
  logic pok_r    [NGRP];
  key_t pkey_r   [NGRP];
  val_t pval_r   [NGRP];

  // Keys are unique in the table, so at most one cell hits: plain OR works.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      hit_c[g]  = 1'b0;
      idx_c[g]  = '0;
      val_c[g]  = '0;
      pok_c[g]  = 1'b0;
      pkey_c[g] = '0;
      pval_c[g] = '0;
    end
    for (int i = 0; i < DEPTH; i++) begin
      hit_c[i / GRP]  = hit_c[i / GRP]  | match[i];
      idx_c[i / GRP]  = idx_c[i / GRP]  | (match[i] ? idx_t'(i) : '0);
      val_c[i / GRP]  = val_c[i / GRP]  | (match[i] ? vals[i] : '0);
      pok_c[i / GRP]  = pok_c[i / GRP]  | pos_hit[i];
      pkey_c[i / GRP] = pkey_c[i / GRP] | (pos_hit[i] ? keys[i] : '0);
      pval_c[i / GRP] = pval_c[i / GRP] | (pos_hit[i] ? vals[i] : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cap) begin
      for (int g = 0; g < NGRP; g++) begin
        hit_r[g]  <= hit_c[g];
        idx_r[g]  <= idx_c[g];
        val_r[g]  <= val_c[g];
        pok_r[g]  <= pok_c[g];
        pkey_r[g] <= pkey_c[g];
        pval_r[g] <= pval_c[g];
      end
    end
  end

  always_comb begin
    res = '0;
    for (int g = 0; g < NGRP; g++) begin
      res.hit     = res.hit     | hit_r[g];
      res.hit_idx = res.hit_idx | idx_r[g];
      res.hit_val = res.hit_val | val_r[g];
      res.pos_ok  = res.pos_ok  | pok_r[g];
      res.pos_key = res.pos_key | pkey_r[g];
      res.pos_val = res.pos_val | pval_r[g];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/okvt_checker.sv -----
// Port-level checks for the ordered key/value table, bound to the top level.
// Uses okvt_pkg for the result type.
`default_nettype none

module okvt_props import okvt_pkg::*; (
  input wire  clk,
  input wire  rst_n,
  input wire  in_valid,
  input wire  in_ready,
  input wire  out_valid,
  input wire  out_ready,
  input res_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request at a time: busy the cycle after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one resolves");

  // empty flag agrees with the count
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_empty == (out_data.entry_count == '0)))
    else $error("is_empty disagrees with entry_count");

  // reset drops any pending result
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ordered_key_value_table_top okvt_props u_okvt_props (.*);

`default_nettype wire

// ----- test/okvt_checker.sv -----
// Checker for the ordered key/value table: mirrors the table contents, predicts
// one result per accepted request and compares results in order.
// Depends on okvt_pkg for the request/result structs and opcodes.
module okvt_checker import okvt_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  input  wire  in_ready,
  input  req_t in_data,
  input  wire  out_valid,
  input  wire  out_ready,
  input  res_t out_data,
  output int   fail_count,
  output int   pending,
  output int   ok_count,
  output int   peak_fill
);
  timeunit 1ns;
  timeprecision 1ps;

  key_t key_slot [DEPTH];
  val_t val_slot [DEPTH];
  int   fill = 0;
  int   fails = 0;
  int   oks = 0;
  int   peak = 0;
  res_t result_q [$];
  res_t want;

  assign fail_count = fails;
  assign pending    = result_q.size();
  assign ok_count   = oks;
  assign peak_fill  = peak;

  // First match in position order, or fill when absent.
  function automatic int find_slot(key_t k);
    for (int i = 0; i < fill; i++) begin
      if (key_slot[i] == k) return i;
    end
    return fill;
  endfunction

  // Applies one request to the mirrored table and returns its result.
  function automatic res_t apply_request(req_t r);
    res_t res;
    key_t k;
    val_t v;
    int   p;
    k = key_t'(r.key);
    v = val_t'(r.new_value);
    res = '0;
    res.found_key = 32'(k);
    p = find_slot(k);
    case (r.opcode)
      OP_INSERT: begin
        if (p == fill && fill < DEPTH) begin
          key_slot[fill] = k;
          val_slot[fill] = v;
          fill++;
          res.ok = 1'b1;
        end
      end
      OP_UPDATE: begin
        if (p < fill) begin
          val_slot[p] = v;
          res.ok = 1'b1;
        end
      end
      OP_UPSERT: begin
        if (p < fill) begin
          val_slot[p] = v;
          res.ok = 1'b1;
        end else if (fill < DEPTH) begin
          key_slot[fill] = k;
          val_slot[fill] = v;
          fill++;
          res.ok = 1'b1;
        end
      end
      OP_ERASE: begin
        if (p < fill) begin
          for (int j = p; j + 1 < fill; j++) begin
            key_slot[j] = key_slot[j+1];
            val_slot[j] = val_slot[j+1];
          end
          fill--;
          res.ok = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (p < fill) begin
          res.ok = 1'b1;
          res.found_value = 32'(val_slot[p]);
        end
      end
      OP_READ: begin
        if (int'(r.position) < fill) begin
          res.ok = 1'b1;
          res.found_key = 32'(key_slot[r.position]);
          res.found_value = 32'(val_slot[r.position]);
        end else begin
          res.found_key = '0;
        end
      end
      default: begin
      end
    endcase
    res.entry_count = 9'(fill);
    res.is_empty = (fill == 0);
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      fill = 0;
      result_q.delete();
    end else begin
      // results leave before new requests enter: no result returns in its request's accept cycle
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result 0x%0h with no request outstanding", out_data);
          fails++;
        end else begin
          want = result_q.pop_front();
          check_field("ok", 32'(want.ok), 32'(out_data.ok));
          check_field("found_key", want.found_key, out_data.found_key);
          check_field("found_value", want.found_value, out_data.found_value);
          check_field("entry_count", 32'(want.entry_count), 32'(out_data.entry_count));
          check_field("is_empty", 32'(want.is_empty), 32'(out_data.is_empty));
          if (out_data.ok === 1'b1) oks++;
        end
      end
      if (in_valid && in_ready) begin
        result_q.push_back(apply_request(in_data));
        if (fill > peak) peak = fill;
      end
    end
  end

endmodule

// ----- test/ordered_key_value_table_top_tb.sv -----
// Testbench top for the ordered key/value table: clock, reset, request
// stimulus and verdict. Depends on okvt_pkg, okvt_checker and the block's RTL.
module ordered_key_value_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import okvt_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  res_t out_data;

  int fail_count;
  int pending;
  int ok_count;
  int peak_fill;

  // Percent of cycles in which the request side holds back / the result
  // side stalls. Zeroed for the no-idle stretch of the fill phase.
  int idle_pct = 27;
  int stall_pct = 27;
  int sent_count = 0;
  int directed_count = 0;

  // Per-run scramble so that the pooled keys toggle every bit.
  logic [31:0] key_salt;

  always #5 clk = ~clk;

  ordered_key_value_table_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  okvt_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .ok_count   (ok_count),
    .peak_fill  (peak_fill)
  );

  // Result side: random back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Pooled key n: distinct for distinct n, spread over all 32 bits.
  function automatic logic [31:0] pool_key(int n);
    return key_salt ^ (32'(n) * 32'h9E37_79B1);
  endfunction

  function automatic req_t mk_req(logic [2:0] op, logic [31:0] k, logic [31:0] v,
                                  logic [7:0] pos);
    req_t r;
    r.opcode = op;
    r.key = k;
    r.new_value = v;
    r.position = pos;
    return r;
  endfunction

  // One request: optional random gap, then hold valid until accepted.
  // Valid stays high on exit so back-to-back requests need no re-raise;
  // only the gap loop or wait_results lowers it.
  task automatic send_req(req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  // Stop sending and wait for every outstanding result. Sampled on the
  // falling edge to stay clear of the checker's updates.
  task automatic wait_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Random operation code, a few percent of them the unused codes.
  function automatic logic [2:0] any_op();
    if ($urandom_range(99) < 5) return 3'($urandom_range(6, 7));
    return 3'($urandom_range(int'(OP_INSERT), int'(OP_READ)));
  endfunction

  // Run limit, far beyond the slowest legal run.
  initial begin
    #2ms;
    $display("ordered_key_value_table_top regression: fail");
    $finish;
  end

  initial begin
    logic [2:0]  op;
    logic [31:0] k;
    logic [7:0]  pos;
    int          roll;

    key_salt = $urandom;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- Directed: corner cases on a table that starts empty ----
    send_req(mk_req(OP_ERASE,  32'h0,          32'h0,          8'd0));   // erase, empty table
    send_req(mk_req(OP_LOOKUP, 32'hFFFF_FFFF,  32'h0,          8'd0));   // lookup miss
    send_req(mk_req(OP_READ,   32'h1234_5678,  32'h0,          8'd0));   // read past count
    send_req(mk_req(OP_UPDATE, 32'h5,          32'h1,          8'd0));   // update absent key
    send_req(mk_req(OP_INSERT, 32'h0,          32'hFFFF_FFFF,  8'd0));   // min key, max value
    send_req(mk_req(OP_INSERT, 32'hFFFF_FFFF,  32'h0,          8'd255)); // max key, min value
    send_req(mk_req(OP_INSERT, 32'h0,          32'h7777_7777,  8'd0));   // duplicate insert
    send_req(mk_req(OP_UPSERT, 32'h0,          32'h1234_5678,  8'd0));   // upsert -> update
    send_req(mk_req(OP_UPSERT, 32'h8000_0001,  32'hA5A5_A5A5,  8'd0));   // upsert -> insert
    send_req(mk_req(OP_UPDATE, 32'hFFFF_FFFF,  32'h5A5A_5A5A,  8'd0));   // update hit
    send_req(mk_req(OP_LOOKUP, 32'h0,          32'hFFFF_FFFF,  8'd0));   // lookup hit
    send_req(mk_req(OP_LOOKUP, 32'h12,         32'h0,          8'd0));   // lookup miss
    send_req(mk_req(OP_READ,   32'h0,          32'h0,          8'd2));   // read last entry
    send_req(mk_req(OP_READ,   32'hFFFF_FFFF,  32'h0,          8'd255)); // read far past count
    send_req(mk_req(OP_READ,   32'h0,          32'h0,          8'd3));   // read at count
    send_req(mk_req(3'd6,      32'hDEAD_BEEF,  32'hFFFF_FFFF,  8'd1));   // unused code
    send_req(mk_req(3'd7,      32'h0,          32'h0,          8'd0));   // unused code
    send_req(mk_req(OP_ERASE,  32'hFFFF_FFFF,  32'h0,          8'd0));   // erase middle, shift
    send_req(mk_req(OP_READ,   32'h0,          32'h0,          8'd1));   // shifted entry
    send_req(mk_req(OP_ERASE,  32'h0,          32'h0,          8'd0));   // erase first
    send_req(mk_req(OP_ERASE,  32'h8000_0001,  32'h0,          8'd0));   // erase last -> empty
    send_req(mk_req(OP_LOOKUP, 32'h0,          32'h0,          8'd0));   // lookup, empty again
    directed_count = sent_count;
    wait_results();

    // ---- Fill: fresh keys in sequence until the table overflows ----
    // First half runs with no idling on either side.
    idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < 300; i++) begin
      if (i == 150) begin
        idle_pct = 27;
        stall_pct = 27;
      end
      roll = $urandom_range(99);
      pos = 8'($urandom_range(255));
      if (roll < 85) begin
        send_req(mk_req(OP_INSERT, pool_key(i), $urandom, pos));
      end else if (roll < 92) begin
        send_req(mk_req(OP_UPSERT, pool_key(i), $urandom, pos));
      end else if (roll < 96) begin
        send_req(mk_req(OP_LOOKUP, pool_key($urandom_range(0, i)), $urandom, pos));
      end else begin
        send_req(mk_req(OP_READ, $urandom, $urandom, pos));
      end
    end
    // table is full here: new keys bounce, present keys still update
    send_req(mk_req(OP_INSERT, pool_key(400), $urandom, 8'd0));
    send_req(mk_req(OP_UPSERT, pool_key(401), $urandom, 8'd0));
    send_req(mk_req(OP_UPSERT, pool_key(0), $urandom, 8'd0));
    send_req(mk_req(OP_READ, $urandom, $urandom, 8'd255));
    wait_results();

    // ---- Thin out: erases of pooled keys, scattered reads ----
    for (int i = 0; i < 200; i++) begin
      roll = $urandom_range(99);
      k = pool_key($urandom_range(0, 299));
      pos = 8'($urandom_range(255));
      if (roll < 70) begin
        op = OP_ERASE;
      end else if (roll < 80) begin
        op = OP_LOOKUP;
      end else if (roll < 90) begin
        op = OP_READ;
      end else begin
        op = OP_UPDATE;
      end
      send_req(mk_req(op, k, $urandom, pos));
    end

    // ---- Mixed: small key pool so most requests hit, some noise keys ----
    for (int i = 0; i < 300; i++) begin
      op = any_op();
      k = ($urandom_range(99) < 5) ? $urandom : pool_key($urandom_range(0, 23));
      pos = ($urandom_range(99) < 75) ? 8'($urandom_range(31)) : 8'($urandom_range(255));
      send_req(mk_req(op, k, $urandom, pos));
    end

    // ---- Sweep: erase pooled keys in order with random requests mixed in, the table drains toward empty ----
    for (int i = 0; i < 300; i++) begin
      if ($urandom_range(99) < 80) begin
        send_req(mk_req(OP_ERASE, pool_key(i), $urandom, 8'($urandom_range(255))));
      end else begin
        send_req(mk_req(any_op(), pool_key($urandom_range(0, 299)), $urandom,
                        8'($urandom_range(255))));
      end
    end

    wait_results();
    // let the clock run on to catch any stray result after the last one
    repeat (8) @(posedge clk);
    @(negedge clk);

    $display("Sent %0d requests (%0d directed); %0d results succeeded.",
             sent_count, directed_count, ok_count);
    $display("Table filled to %0d of %0d entries, overflowed and drained back down.",
             peak_fill, DEPTH);
    if (fail_count == 0 && pending == 0) begin
      $display("ordered_key_value_table_top regression: pass");
    end else begin
      $display("ordered_key_value_table_top regression: fail");
    end
    $finish;
  end

endmodule
